// ===== hdl/pcfs_pkg.sv =====
// Package with the shared types, codes and palette table of the palette fade sequencer.
package pcfs_pkg;

  localparam int unsigned PALETTE_SIZE_DEF = 6;
  localparam int unsigned COLOR_COUNT      = 6;
  localparam int unsigned CH_COUNT         = 3;
  localparam int unsigned ENTRY_W          = 4;
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned CHAN_W           = 8;
  localparam int unsigned FROM_W           = 3;
  localparam int unsigned PROD_W           = 24;
  localparam int unsigned QUO_W            = 8;

  localparam logic [15:0] STEP_PERIOD_RST  = 16'd40;
  localparam logic [15:0] BLEND_PERIOD_RST = 16'd900;
  localparam logic [1:0]  CH_LAST          = 2'(CH_COUNT - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_ENABLE  = 2'd1,
    MODE_DISABLE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD  = 2'd0,
    CFG_BLEND_PERIOD = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PHASE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [15:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  localparam logic [CHAN_W-1:0] COLORS [COLOR_COUNT][CH_COUNT] = '{
    '{8'd228, 8'd3,   8'd3},
    '{8'd255, 8'd140, 8'd0},
    '{8'd255, 8'd237, 8'd0},
    '{8'd0,   8'd128, 8'd38},
    '{8'd0,   8'd77,  8'd255},
    '{8'd117, 8'd7,   8'd135}
  };

  // Entries past the end of the table read as black.
  function automatic logic [CHAN_W-1:0] color_of(logic [ENTRY_W-1:0] entry, logic [1:0] ch);
    logic [CHAN_W-1:0] val;
    val = '0;
    if ((entry < ENTRY_W'(COLOR_COUNT)) && (ch <= CH_LAST)) begin
      val = COLORS[3'(entry)][ch];
    end
    return val;
  endfunction

endpackage

// ===== hdl/pcfs_intf.sv =====
// Handshake interfaces for the configuration, input and output channels.
interface pcfs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pcfs_pkg::CFG_IDX_W-1:0]     index;
  logic [pcfs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface pcfs_in_if;
  logic                               valid;
  logic                               ready;
  logic [pcfs_pkg::MODE_W-1:0]        mode;
  logic [pcfs_pkg::TIME_W-1:0]        now_ms;

  modport source (output valid, output mode, output now_ms, input ready);
  modport sink (input valid, input mode, input now_ms, output ready);
endinterface

interface pcfs_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcfs_pkg::CHAN_W-1:0]        red;
  logic [pcfs_pkg::CHAN_W-1:0]        green;
  logic [pcfs_pkg::CHAN_W-1:0]        blue;
  logic [pcfs_pkg::FROM_W-1:0]        from_entry;
  logic                               lit;

  modport source (output valid, output red, output green, output blue,
                  output from_entry, output lit, input ready);
  modport sink (input valid, input red, input green, input blue,
                input from_entry, input lit, output ready);
endinterface

// ===== hdl/pcfs_div.sv =====
// Shared restoring divider, one quotient bit per cycle, for quotients below 256.
module pcfs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcfs_pkg::div_req_t  req_i,
  output pcfs_pkg::div_rsp_t  rsp_o
);
  import pcfs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [2:0]        cnt_q;
  logic [PROD_W-1:0] rem_q;
  logic [PROD_W-1:0] dsr_q;
  logic [QUO_W-1:0]  quo_q;
  logic              ge;

  assign ge = rem_q >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dsr_q <= PROD_W'(req_i.divisor) << (QUO_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_q - dsr_q) : rem_q;
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/palette_color_fade_sequencer_core.sv =====
// Top level of the palette fade sequencer: event sequencer, crossfade datapath and output register.
//
//   channel  dir  payload                                 word accepted when
//   cfg_i    in   index, data                             valid && ready
//   in_i     in   mode, now_ms                            valid && ready
//   out_o    out  red, green, blue, from_entry, lit       valid && ready
//
// An enable, an ignored event or a tick while stopped is handled in the idle state; an early tick ends after the check.
// A disable goes straight to the emit state; an emitted tick runs check, phase and, for each of the three color
// channels, a multiply and a pass through the shared divider, which is skipped with a zero blend period.
// Input ready is high only while the sequencer is idle.
// A finished word waits in the output register while the next input word is taken.
// Reset restores the default periods, stops the animation and clears the last-step and fade-start times.
module palette_color_fade_sequencer_core #(
  parameter int unsigned PALETTE_SIZE = pcfs_pkg::PALETTE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcfs_cfg_if.sink   cfg_i,
  pcfs_in_if.sink    in_i,
  pcfs_out_if.source out_o
);
  import pcfs_pkg::*;

  localparam int unsigned   PosW    = $clog2(PALETTE_SIZE);
  localparam logic [PosW-1:0] PosLast = PosW'(PALETTE_SIZE - 1);

  state_e            state_q, state_d;
  logic              running_q;
  logic [TIME_W-1:0] last_q;
  logic [TIME_W-1:0] fade_q;
  logic [PosW-1:0]   pos_q;
  logic [TIME_W-1:0] now_q;
  logic [15:0]       elapsed_q;
  logic [1:0]        ch_q;
  logic [CHAN_W-1:0] a_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [CHAN_W-1:0] res_q [CH_COUNT];
  logic              blank_q;
  logic [15:0]       step_q;
  logic [15:0]       blend_q;

  logic              out_valid_q;
  logic [CHAN_W-1:0] out_red_q, out_green_q, out_blue_q;
  logic [FROM_W-1:0] out_from_q;
  logic              out_lit_q;

  logic              in_acc, cfg_acc, out_free, early, seg_done, blend_zero, neg;
  logic [TIME_W-1:0] diff, elapsed_full;
  logic [PosW-1:0]   pos_nxt;
  logic [CHAN_W-1:0] col_a, col_b, mag, mix;
  logic [PROD_W-1:0] prod_w;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign diff         = now_q - last_q;
  assign early        = diff < TIME_W'(step_q);
  assign elapsed_full = now_q - fade_q;
  assign seg_done     = elapsed_full >= TIME_W'(blend_q);
  assign blend_zero   = (blend_q == '0);
  assign pos_nxt      = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);

  assign col_a  = color_of(ENTRY_W'(pos_q), ch_q);
  assign col_b  = color_of(ENTRY_W'(pos_nxt), ch_q);
  assign neg    = col_b < col_a;
  assign mag    = neg ? (col_a - col_b) : (col_b - col_a);
  assign prod_w = PROD_W'(mag) * PROD_W'(elapsed_q);
  assign mix    = neg_q ? (a_q - div_rsp.quotient) : (a_q + div_rsp.quotient);

  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = blend_q;

  pcfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.mode)
            MODE_TICK:    state_d = running_q ? ST_CHECK : ST_IDLE;
            MODE_DISABLE: state_d = ST_EMIT;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK:  state_d = early ? ST_IDLE : ST_PHASE;
      ST_PHASE:  state_d = ST_MUL;
      ST_MUL: begin
        if (!blend_zero) begin
          state_d = ST_DIV_GO;
        end else if (ch_q == CH_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = (ch_q == CH_LAST) ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT:   state_d = out_free ? ST_IDLE : ST_EMIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_PERIOD_RST;
      blend_q   <= BLEND_PERIOD_RST;
      running_q <= 1'b0;
      last_q    <= '0;
      fade_q    <= '0;
      pos_q     <= '0;
      ch_q      <= '0;
      blank_q   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_i.index)
          CFG_STEP_PERIOD:  step_q  <= cfg_i.data;
          CFG_BLEND_PERIOD: blend_q <= cfg_i.data;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.mode)
              MODE_TICK: blank_q <= 1'b0;
              MODE_ENABLE: begin
                if (!running_q) begin
                  running_q <= 1'b1;
                  pos_q     <= '0;
                  fade_q    <= in_i.now_ms;
                  last_q    <= '0;
                end
              end
              MODE_DISABLE: begin
                running_q <= 1'b0;
                blank_q   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          if (!early) begin
            last_q <= now_q;
          end
        end
        ST_PHASE: begin
          ch_q <= '0;
          if (seg_done) begin
            pos_q  <= pos_nxt;
            fade_q <= now_q;
          end
        end
        ST_MUL: begin
          if (blend_zero) begin
            ch_q <= ch_q + 2'd1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            ch_q <= ch_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= in_i.now_ms;
    end
    if (state_q == ST_PHASE) begin
      elapsed_q <= seg_done ? '0 : elapsed_full[15:0];
    end
    if (state_q == ST_MUL) begin
      a_q    <= col_a;
      neg_q  <= neg;
      prod_q <= prod_w;
      if (blend_zero) begin
        res_q[ch_q] <= col_b;
      end
    end
    if ((state_q == ST_DIV_WAIT) && div_rsp.done) begin
      res_q[ch_q] <= mix;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_red_q   <= blank_q ? '0 : res_q[0];
      out_green_q <= blank_q ? '0 : res_q[1];
      out_blue_q  <= blank_q ? '0 : res_q[2];
      out_from_q  <= FROM_W'(pos_q);
      out_lit_q   <= !blank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.red        = out_red_q;
  assign out_o.green      = out_green_q;
  assign out_o.blue       = out_blue_q;
  assign out_o.from_entry = out_from_q;
  assign out_o.lit        = out_lit_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("Palette position left the palette.");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("Output word appeared without an emit step.");

  a_enable_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.mode == MODE_ENABLE) && !running_q) |=>
      (running_q && (pos_q == '0)))
    else $error("Enable from the stopped state did not restart the palette.");

endmodule
